// ===== sv/acmm_pkg.sv =====
// Shared types, constants and helpers for the audio channel matrix mixer.
// Used by every module of the mixer; depends on nothing.
package acmm_pkg;

   // Frame geometry and sample format.
   localparam int LANES          = 4;
   localparam int SAMPLE_WIDTH   = 32;
   localparam int MAX_CHANNELS   = 4;
   localparam int CH_COUNT_WIDTH = 3;
   localparam int CLIP_WIDTH     = 32;

   // Coefficient format: signed fixed point with a fixed fraction size.
   localparam int COEF_WIDTH_DEFAULT = 16;
   localparam int COEF_FRAC          = 12;
   localparam int COEF_STRIDE        = 16;

   // Configuration port geometry.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   // Saturation bounds of one output sample.
   localparam longint SAMPLE_MAX = 64'sd2147483647;
   localparam longint SAMPLE_MIN = -64'sd2147483648;

   // Channel counts above this act as this value.
   localparam int CH_LIMIT = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEF_ROW_0,
      CSR_COEF_ROW_1,
      CSR_COEF_ROW_2,
      CSR_COEF_ROW_3,
      CSR_IN_CHANNELS,
      CSR_OUT_CHANNELS,
      CSR_FIRST_ROW_ONLY
   } csr_index_type;

   // Reset values: identity matrix, two channels in and out.
   localparam logic [CSR_DATA_WIDTH-1:0] COEF_ROW_RESET [LANES] = '{
      64'h0000_0000_0000_1000,
      64'h0000_0000_1000_0000,
      64'h0000_1000_0000_0000,
      64'h1000_0000_0000_0000
   };
   localparam logic [CH_COUNT_WIDTH-1:0] IN_CHANNELS_RESET  = 3'd2;
   localparam logic [CH_COUNT_WIDTH-1:0] OUT_CHANNELS_RESET = 3'd2;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   // Load strobes for the two register stages inside each lane.
   typedef struct packed {
      logic load_prod;
      logic load_sum;
   } stage_ctrl_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      sample_type value;
      logic       clip;
   } lane_result_type;

   // Clamp a configured channel count to the number of channels present.
   function automatic logic [CH_COUNT_WIDTH-1:0] active_count(
      input logic [CH_COUNT_WIDTH-1:0] cfg
   );
      logic [CH_COUNT_WIDTH-1:0] lim;
      lim = CH_COUNT_WIDTH'(CH_LIMIT);
      return (cfg > lim) ? lim : cfg;
   endfunction

endpackage

// ===== sv/acmm_if.sv =====
// Valid/ready channel interfaces for the mixer's frame input and mixed output.
// Depends on acmm_pkg for the sample type and widths.

// Input frame channel.
interface acmm_req_if;
   logic                 valid;
   logic                 ready;
   acmm_pkg::sample_type sample_0;
   acmm_pkg::sample_type sample_1;
   acmm_pkg::sample_type sample_2;
   acmm_pkg::sample_type sample_3;

   modport source (output valid, sample_0, sample_1, sample_2, sample_3, input ready);
   modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

// Mixed output channel.
interface acmm_rsp_if;
   logic                                valid;
   logic                                ready;
   acmm_pkg::sample_type                mixed_0;
   acmm_pkg::sample_type                mixed_1;
   acmm_pkg::sample_type                mixed_2;
   acmm_pkg::sample_type                mixed_3;
   logic [acmm_pkg::LANES-1:0]          clip_mask;
   logic [acmm_pkg::CLIP_WIDTH-1:0]     clip_total;

   modport source (output valid, mixed_0, mixed_1, mixed_2, mixed_3, clip_mask, clip_total,
                   input ready);
   modport sink   (input valid, mixed_0, mixed_1, mixed_2, mixed_3, clip_mask, clip_total,
                   output ready);
endinterface

// ===== sv/acmm_lane.sv =====
// One output-channel lane: four multipliers, an adder and the saturating truncation.
// Depends on acmm_pkg; instantiated once per output channel by the top level.
module acmm_lane #(
   parameter int COEF_WIDTH = acmm_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  acmm_pkg::stage_ctrl_type         ctrl,
   input  acmm_pkg::sample_type             sample [acmm_pkg::LANES],
   input  logic signed [COEF_WIDTH-1:0]     coef   [acmm_pkg::LANES],
   input  logic [acmm_pkg::LANES-1:0]       in_mask,
   input  logic                             active,
   output acmm_pkg::lane_result_type        result
);

   localparam int PW      = acmm_pkg::SAMPLE_WIDTH + COEF_WIDTH;
   localparam int MIN_SW  = acmm_pkg::SAMPLE_WIDTH + acmm_pkg::COEF_FRAC + 1;
   localparam int SW      = (PW + 2 > MIN_SW) ? PW + 2 : MIN_SW;
   localparam longint UNIT = longint'(1) <<< acmm_pkg::COEF_FRAC;
   localparam logic signed [SW-1:0] LIMIT_HI = SW'(acmm_pkg::SAMPLE_MAX * UNIT);
   localparam logic signed [SW-1:0] LIMIT_LO = SW'(acmm_pkg::SAMPLE_MIN * UNIT);

   logic signed [PW-1:0] prod_in [acmm_pkg::LANES];
   logic signed [PW-1:0] prod_ff [acmm_pkg::LANES];
   logic signed [SW-1:0] sum_in;
   logic signed [SW-1:0] sum_ff;
   logic signed [SW-1:0] bias;
   logic signed [SW-1:0] adj;
   logic signed [SW-1:0] quot;

   // Products of the active inputs; inactive inputs contribute zero.
   always_comb begin
      for (int i = 0; i < acmm_pkg::LANES; i++) begin
         prod_in[i] = in_mask[i] ? PW'(sample[i]) * PW'(coef[i]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
   end

   // Exact sum of the products.
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < acmm_pkg::LANES; i++) begin
         sum_in = sum_in + SW'(prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   // Drop the fraction rounding toward zero; saturate when the unscaled sum is out of range; inactive lanes give zero.
   always_comb begin
      bias = sum_ff[SW-1] ? SW'(UNIT - 1) : '0;
      adj  = sum_ff + bias;
      quot = adj >>> acmm_pkg::COEF_FRAC;
      result.clip  = 1'b0;
      result.value = '0;
      if (active) begin
         if (sum_ff > LIMIT_HI) begin
            result.clip  = 1'b1;
            result.value = acmm_pkg::SAMPLE_WIDTH'(acmm_pkg::SAMPLE_MAX);
         end else if (sum_ff < LIMIT_LO) begin
            result.clip  = 1'b1;
            result.value = acmm_pkg::SAMPLE_WIDTH'(acmm_pkg::SAMPLE_MIN);
         end else begin
            result.value = $signed(quot[acmm_pkg::SAMPLE_WIDTH-1:0]);
         end
      end
   end

endmodule

// ===== sv/acmm_merge.sv =====
// Merging stage: registers the lane results, builds the clip mask, keeps the clip count.
// Depends on acmm_pkg; fed by the four acmm_lane instances.
module acmm_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  acmm_pkg::lane_result_type       lane_res [acmm_pkg::LANES],
   output acmm_pkg::sample_type            mixed    [acmm_pkg::LANES],
   output logic [acmm_pkg::LANES-1:0]      clip_mask,
   output logic [acmm_pkg::CLIP_WIDTH-1:0] clip_total
);

   acmm_pkg::sample_type            mixed_ff [acmm_pkg::LANES];
   logic [acmm_pkg::LANES-1:0]      mask_in;
   logic [acmm_pkg::LANES-1:0]      mask_ff;
   logic [acmm_pkg::CLIP_WIDTH-1:0] count_in;
   logic [acmm_pkg::CLIP_WIDTH-1:0] count_ff;
   logic [acmm_pkg::CLIP_WIDTH:0]   count_sum;

   // Collect clip flags and advance the saturating clip counter.
   always_comb begin
      for (int j = 0; j < acmm_pkg::LANES; j++) begin
         mask_in[j] = lane_res[j].clip;
      end
      count_sum = {1'b0, count_ff} + (acmm_pkg::CLIP_WIDTH + 1)'($countones(mask_in));
      count_in  = count_sum[acmm_pkg::CLIP_WIDTH] ? '1 : count_sum[acmm_pkg::CLIP_WIDTH-1:0];
   end

   // Output word registers.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int j = 0; j < acmm_pkg::LANES; j++) begin
            mixed_ff[j] <= lane_res[j].value;
         end
         mask_ff <= mask_in;
      end
   end

   // Clip counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= count_in;
      end
   end

   assign mixed      = mixed_ff;
   assign clip_mask  = mask_ff;
   assign clip_total = count_ff;

endmodule

// ===== sv/audio_channel_matrix_mixer_unit.sv =====
// Audio channel matrix mixer: a 4x4 signed coefficient matrix applied to each frame.
// Depends on acmm_pkg, acmm_if, acmm_lane and acmm_merge.
//
// Usage:
//   req_ch carries one frame word of four signed 32-bit samples; rsp_ch returns one
//   word of four mixed samples, a per-channel clip mask and the running clip count.
//   Both are valid/ready channels; a word moves when valid and ready are both high.
//   The csr_ port writes coefficient rows, channel counts and the first-row-only
//   flag; write it only while no frame is in flight.
// Pipeline and throughput:
//   An accepted frame is registered in the lane product registers, then in the lane
//   sum registers and then in the merging output register, which drives rsp_ch.
//   One frame is accepted per cycle while rsp_ch is not stalled; four lanes, one per
//   output channel, each run four multipliers in parallel.
// Reset:
//   Synchronous reset empties the pipeline, clears the clip counter and loads the
//   identity matrix with two input and two output channels.
// Stalls:
//   Each stage holds its word while the next stage is full and not moving, so a
//   stalled receiver fills the bubbles first and then drops req_ch.ready.
module audio_channel_matrix_mixer_unit #(
   parameter int COEF_WIDTH = acmm_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   acmm_req_if.sink                             req_ch,
   acmm_rsp_if.source                           rsp_ch,
   input  logic                                 csr_write_enable,
   input  logic [acmm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [acmm_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int EXT_WIDTH = acmm_pkg::CSR_DATA_WIDTH + COEF_WIDTH;

   logic [acmm_pkg::CSR_DATA_WIDTH-1:0] coef_row_ff [acmm_pkg::LANES];
   logic [acmm_pkg::CH_COUNT_WIDTH-1:0] in_channels_ff;
   logic [acmm_pkg::CH_COUNT_WIDTH-1:0] out_channels_ff;
   logic                                first_row_only_ff;

   logic valid_prod_ff, valid_sum_ff, valid_out_ff;
   logic ready_prod, ready_sum, ready_out;
   acmm_pkg::stage_ctrl_type ctrl;
   logic load_out;

   acmm_pkg::sample_type              samples [acmm_pkg::LANES];
   logic signed [COEF_WIDTH-1:0]      coef    [acmm_pkg::LANES][acmm_pkg::LANES];
   logic [EXT_WIDTH-1:0]              row_ext;
   logic [acmm_pkg::LANES-1:0]        in_mask;
   logic [acmm_pkg::LANES-1:0]        out_active;
   logic [acmm_pkg::CH_COUNT_WIDTH-1:0] ni, no;

   acmm_pkg::lane_result_type lane_res [acmm_pkg::LANES];
   acmm_pkg::sample_type      mixed    [acmm_pkg::LANES];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_row_ff       <= acmm_pkg::COEF_ROW_RESET;
         in_channels_ff    <= acmm_pkg::IN_CHANNELS_RESET;
         out_channels_ff   <= acmm_pkg::OUT_CHANNELS_RESET;
         first_row_only_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            acmm_pkg::CSR_COEF_ROW_0:     coef_row_ff[0]    <= csr_write_data;
            acmm_pkg::CSR_COEF_ROW_1:     coef_row_ff[1]    <= csr_write_data;
            acmm_pkg::CSR_COEF_ROW_2:     coef_row_ff[2]    <= csr_write_data;
            acmm_pkg::CSR_COEF_ROW_3:     coef_row_ff[3]    <= csr_write_data;
            acmm_pkg::CSR_IN_CHANNELS:
               in_channels_ff  <= csr_write_data[acmm_pkg::CH_COUNT_WIDTH-1:0];
            acmm_pkg::CSR_OUT_CHANNELS:
               out_channels_ff <= csr_write_data[acmm_pkg::CH_COUNT_WIDTH-1:0];
            acmm_pkg::CSR_FIRST_ROW_ONLY: first_row_only_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow control: a stage moves when the next one is empty or moving.
   assign ready_out      = !valid_out_ff || rsp_ch.ready;
   assign ready_sum      = !valid_sum_ff || ready_out;
   assign ready_prod     = !valid_prod_ff || ready_sum;
   assign req_ch.ready   = ready_prod;
   assign ctrl.load_prod = req_ch.valid && ready_prod;
   assign ctrl.load_sum  = valid_prod_ff && ready_sum;
   assign load_out       = valid_sum_ff && ready_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_prod_ff <= 1'b0;
         valid_sum_ff  <= 1'b0;
         valid_out_ff  <= 1'b0;
      end else begin
         if (ready_prod) begin
            valid_prod_ff <= req_ch.valid;
         end
         if (ready_sum) begin
            valid_sum_ff <= valid_prod_ff;
         end
         if (ready_out) begin
            valid_out_ff <= valid_sum_ff;
         end
      end
   end

   // Coefficient selection and channel masks.
   assign samples[0] = req_ch.sample_0;
   assign samples[1] = req_ch.sample_1;
   assign samples[2] = req_ch.sample_2;
   assign samples[3] = req_ch.sample_3;
   assign ni = acmm_pkg::active_count(in_channels_ff);
   assign no = acmm_pkg::active_count(out_channels_ff);

   always_comb begin
      row_ext = '0;
      for (int i = 0; i < acmm_pkg::LANES; i++) begin
         in_mask[i]    = acmm_pkg::CH_COUNT_WIDTH'(i) < ni;
         out_active[i] = acmm_pkg::CH_COUNT_WIDTH'(i) < no;
         // Bits above the 64-bit row read as zero.
         row_ext = EXT_WIDTH'(first_row_only_ff ? coef_row_ff[0] : coef_row_ff[i]);
         for (int j = 0; j < acmm_pkg::LANES; j++) begin
            coef[j][i] = $signed(row_ext[acmm_pkg::COEF_STRIDE*j +: COEF_WIDTH]);
         end
      end
   end

   // One lane per output channel.
   for (genvar j = 0; j < acmm_pkg::LANES; j++) begin : g_lane
      acmm_lane #(
         .COEF_WIDTH (COEF_WIDTH)
      ) u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .sample  (samples),
         .coef    (coef[j]),
         .in_mask (in_mask),
         .active  (out_active[j]),
         .result  (lane_res[j])
      );
   end

   acmm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load_out),
      .lane_res   (lane_res),
      .mixed      (mixed),
      .clip_mask  (rsp_ch.clip_mask),
      .clip_total (rsp_ch.clip_total)
   );

   assign rsp_ch.valid   = valid_out_ff;
   assign rsp_ch.mixed_0 = mixed[0];
   assign rsp_ch.mixed_1 = mixed[1];
   assign rsp_ch.mixed_2 = mixed[2];
   assign rsp_ch.mixed_3 = mixed[3];

endmodule

// ===== sv/acmm_checker.sv =====
// Port-level checks for the audio channel matrix mixer, bound to the top level.
// Depends on acmm_pkg and the top level audio_channel_matrix_mixer_unit.
module acmm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input acmm_pkg::sample_type                 mixed_0,
   input acmm_pkg::sample_type                 mixed_1,
   input logic [acmm_pkg::LANES-1:0]           clip_mask,
   input logic [acmm_pkg::CLIP_WIDTH-1:0]      clip_total
);

   localparam acmm_pkg::sample_type S_MAX = acmm_pkg::SAMPLE_WIDTH'(acmm_pkg::SAMPLE_MAX);
   localparam acmm_pkg::sample_type S_MIN = acmm_pkg::SAMPLE_WIDTH'(acmm_pkg::SAMPLE_MIN);

   // A stalled output word stays valid, and its clip count, clip mask and mixed_0 hold.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(clip_total) && $stable(clip_mask)
         && $stable(mixed_0))
      else $error("output word changed while stalled");

   // The clip count never goes down while words are shown.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> clip_total >= $past(clip_total))
      else $error("clip count decreased");

   // A clipped channel 0 or 1 shows a saturated value.
   a_clip_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clip_mask[0] |-> mixed_0 == S_MAX || mixed_0 == S_MIN)
      else $error("clip flag without saturated sample on channel 0");

   a_clip_saturates_1: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clip_mask[1] |-> mixed_1 == S_MAX || mixed_1 == S_MIN)
      else $error("clip flag without saturated sample on channel 1");

   // Any clip in the shown word implies a nonzero clip count.
   a_clip_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clip_mask != '0 |-> clip_total != '0)
      else $error("clip flagged but clip count is zero");

endmodule

bind audio_channel_matrix_mixer_unit acmm_checker u_acmm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .mixed_0    (rsp_ch.mixed_0),
   .mixed_1    (rsp_ch.mixed_1),
   .clip_mask  (rsp_ch.clip_mask),
   .clip_total (rsp_ch.clip_total)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the audio channel matrix mixer unit.
// Depends on acmm_pkg, on the acmm_req_if and acmm_rsp_if interfaces and on the unit itself.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_FRAMES = 150;
   localparam int RANDOM_PHASES = 9;

   typedef struct {
      acmm_pkg::sample_type sample [acmm_pkg::LANES];
   } frame_type;

   typedef struct {
      acmm_pkg::sample_type                mixed [acmm_pkg::LANES];
      logic [acmm_pkg::LANES-1:0]          clip_mask;
      logic [acmm_pkg::CLIP_WIDTH-1:0]     clip_total;
   } mix_type;

   typedef struct {
      logic [acmm_pkg::CSR_DATA_WIDTH-1:0] row [acmm_pkg::LANES];
      logic [acmm_pkg::CH_COUNT_WIDTH-1:0] in_count;
      logic [acmm_pkg::CH_COUNT_WIDTH-1:0] out_count;
      logic                                row_zero_only;
   } mix_config_type;

   // Mirrors the mixer's registers and clip counter, and queues the word
   // that each accepted frame must produce.
   class mix_scoreboard;
      logic [acmm_pkg::CSR_DATA_WIDTH-1:0] coef_row [acmm_pkg::LANES];
      logic [acmm_pkg::CH_COUNT_WIDTH-1:0] in_count;
      logic [acmm_pkg::CH_COUNT_WIDTH-1:0] out_count;
      logic                                row_zero_only;
      logic [acmm_pkg::CLIP_WIDTH-1:0]     clip_count;
      mix_type                             expected_mixes [$];
      int                                  mismatches;

      function new();
         coef_row      = acmm_pkg::COEF_ROW_RESET;
         in_count      = acmm_pkg::IN_CHANNELS_RESET;
         out_count     = acmm_pkg::OUT_CHANNELS_RESET;
         row_zero_only = 1'b0;
         clip_count    = '0;
         mismatches    = 0;
      endfunction

      function void write_reg(acmm_pkg::csr_index_type idx,
                              logic [acmm_pkg::CSR_DATA_WIDTH-1:0] data);
         case (idx)
            acmm_pkg::CSR_COEF_ROW_0:     coef_row[0] = data;
            acmm_pkg::CSR_COEF_ROW_1:     coef_row[1] = data;
            acmm_pkg::CSR_COEF_ROW_2:     coef_row[2] = data;
            acmm_pkg::CSR_COEF_ROW_3:     coef_row[3] = data;
            acmm_pkg::CSR_IN_CHANNELS:    in_count = data[acmm_pkg::CH_COUNT_WIDTH-1:0];
            acmm_pkg::CSR_OUT_CHANNELS:   out_count = data[acmm_pkg::CH_COUNT_WIDTH-1:0];
            acmm_pkg::CSR_FIRST_ROW_ONLY: row_zero_only = data[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_mixes.size();
      endfunction

      // Counts above the lane count act as the lane count.
      function int lanes_used(logic [acmm_pkg::CH_COUNT_WIDTH-1:0] cfg);
         return (int'(cfg) > acmm_pkg::CH_LIMIT) ? acmm_pkg::CH_LIMIT : int'(cfg);
      endfunction

      // Exact weighted sum per output, then the clip test on the unscaled sum,
      // otherwise division by one unit truncates toward zero.
      function void note_frame(frame_type f);
         mix_type                                        m;
         longint                                         acc;
         longint                                         res;
         longint                                         unit;
         logic signed [acmm_pkg::COEF_WIDTH_DEFAULT-1:0] c;
         int                                             ni;
         int                                             no;
         int                                             r;
         unit = longint'(1) << acmm_pkg::COEF_FRAC;
         ni = lanes_used(in_count);
         no = lanes_used(out_count);
         m.clip_mask = '0;
         for (int j = 0; j < acmm_pkg::LANES; j++) begin
            res = 0;
            if (j < no) begin
               acc = 0;
               for (int i = 0; i < ni; i++) begin
                  r = row_zero_only ? 0 : i;
                  c = coef_row[r][acmm_pkg::COEF_STRIDE*j +: acmm_pkg::COEF_WIDTH_DEFAULT];
                  acc += longint'(f.sample[i]) * longint'(c);
               end
               if (acc > acmm_pkg::SAMPLE_MAX * unit) begin
                  res = acmm_pkg::SAMPLE_MAX;
                  m.clip_mask[j] = 1'b1;
               end else if (acc < acmm_pkg::SAMPLE_MIN * unit) begin
                  res = acmm_pkg::SAMPLE_MIN;
                  m.clip_mask[j] = 1'b1;
               end else begin
                  res = acc / unit;
               end
               if (m.clip_mask[j] && clip_count != '1) begin
                  clip_count++;
               end
            end
            m.mixed[j] = acmm_pkg::sample_type'(res);
         end
         m.clip_total = clip_count;
         expected_mixes.push_back(m);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_mix(mix_type got);
         mix_type want;
         if (expected_mixes.size() == 0) begin
            report("mixed word arrived with no frame pending");
         end else begin
            want = expected_mixes.pop_front();
            for (int j = 0; j < acmm_pkg::LANES; j++) begin
               if (got.mixed[j] !== want.mixed[j]) begin
                  report($sformatf("mixed_%0d got %0d want %0d", j, got.mixed[j],
                                   want.mixed[j]));
               end
            end
            if (got.clip_mask !== want.clip_mask) begin
               report($sformatf("clip_mask got %b want %b", got.clip_mask, want.clip_mask));
            end
            if (got.clip_total !== want.clip_total) begin
               report($sformatf("clip_total got %0d want %0d", got.clip_total,
                                want.clip_total));
            end
         end
      endtask
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 csr_write_enable;
   logic [acmm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [acmm_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;
   int                                   send_idle_pct = 17;
   int                                   recv_idle_pct = 77;
   int                                   cycle_count = 0;
   mix_scoreboard                        sb = new();

   acmm_req_if req_ch();
   acmm_rsp_if rsp_ch();

   audio_channel_matrix_mixer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watch both channels: accepted frames feed the predictor, accepted words are checked.
   always @(posedge clock) begin
      mix_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_frame('{sample: '{req_ch.sample_0, req_ch.sample_1,
                                      req_ch.sample_2, req_ch.sample_3}});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.mixed[0]  = rsp_ch.mixed_0;
            got.mixed[1]  = rsp_ch.mixed_1;
            got.mixed[2]  = rsp_ch.mixed_2;
            got.mixed[3]  = rsp_ch.mixed_3;
            got.clip_mask  = rsp_ch.clip_mask;
            got.clip_total = rsp_ch.clip_total;
            sb.check_mix(got);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function frame_type make_frame(acmm_pkg::sample_type a, acmm_pkg::sample_type b,
                                  acmm_pkg::sample_type c, acmm_pkg::sample_type d);
      make_frame.sample = '{a, b, c, d};
   endfunction

   // Fully random samples half of the time, otherwise an extreme, a small value or zero.
   function acmm_pkg::sample_type random_sample();
      case ($urandom_range(7))
         0: return acmm_pkg::sample_type'(acmm_pkg::SAMPLE_MAX);
         1: return acmm_pkg::sample_type'(acmm_pkg::SAMPLE_MIN);
         2: return acmm_pkg::sample_type'(int'($urandom_range(200)) - 100);
         3: return '0;
         default: return acmm_pkg::sample_type'($urandom);
      endcase
   endfunction

   function logic [acmm_pkg::COEF_STRIDE-1:0] random_coef();
      case ($urandom_range(6))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h1000;
         3: return 16'hF000;
         4: return 16'h0000;
         5: return 16'($urandom_range(16'h2000)) - 16'h1000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Same coefficient in every position of the matrix.
   function mix_config_type flat_config(logic [acmm_pkg::COEF_STRIDE-1:0] c, int in_n,
                                        int out_n, logic row_zero);
      flat_config.row           = '{acmm_pkg::LANES{{acmm_pkg::LANES{c}}}};
      flat_config.in_count      = acmm_pkg::CH_COUNT_WIDTH'(in_n);
      flat_config.out_count     = acmm_pkg::CH_COUNT_WIDTH'(out_n);
      flat_config.row_zero_only = row_zero;
   endfunction

   function mix_config_type random_config(int in_n, int out_n, logic row_zero);
      random_config = flat_config('0, in_n, out_n, row_zero);
      for (int r = 0; r < acmm_pkg::LANES; r++) begin
         for (int j = 0; j < acmm_pkg::LANES; j++) begin
            random_config.row[r][acmm_pkg::COEF_STRIDE*j +: acmm_pkg::COEF_STRIDE] =
               random_coef();
         end
      end
   endfunction

   task write_reg(acmm_pkg::csr_index_type idx, logic [acmm_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   // Writes every register; the mixer must be idle.
   task program_mixer(mix_config_type cfg);
      write_reg(acmm_pkg::CSR_COEF_ROW_0, cfg.row[0]);
      write_reg(acmm_pkg::CSR_COEF_ROW_1, cfg.row[1]);
      write_reg(acmm_pkg::CSR_COEF_ROW_2, cfg.row[2]);
      write_reg(acmm_pkg::CSR_COEF_ROW_3, cfg.row[3]);
      write_reg(acmm_pkg::CSR_IN_CHANNELS, acmm_pkg::CSR_DATA_WIDTH'(cfg.in_count));
      write_reg(acmm_pkg::CSR_OUT_CHANNELS, acmm_pkg::CSR_DATA_WIDTH'(cfg.out_count));
      write_reg(acmm_pkg::CSR_FIRST_ROW_ONLY, acmm_pkg::CSR_DATA_WIDTH'(cfg.row_zero_only));
      csr_write_enable <= 1'b0;
   endtask

   // Holds off the sender until every expected word has come back. The first
   // edge lets the monitor note a frame taken at the edge this task starts on.
   task settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 1) @(posedge clock);
   endtask

   // Offers one frame after a random gap and returns at the edge it is taken.
   task send_frame(frame_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.sample_0 <= f.sample[0];
      req_ch.sample_1 <= f.sample[1];
      req_ch.sample_2 <= f.sample[2];
      req_ch.sample_3 <= f.sample[3];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      mix_config_type       cfg;
      acmm_pkg::sample_type smax;
      acmm_pkg::sample_type smin;
      int                   in_pick [RANDOM_PHASES] = '{4, 1, 3, 2, 7, 4, 0, 5, 4};
      int                   out_pick [RANDOM_PHASES] = '{4, 4, 1, 2, 4, 6, 3, 0, 4};
      smax = acmm_pkg::sample_type'(acmm_pkg::SAMPLE_MAX);
      smin = acmm_pkg::sample_type'(acmm_pkg::SAMPLE_MIN);
      req_ch.valid     <= 1'b0;
      req_ch.sample_0  <= '0;
      req_ch.sample_1  <= '0;
      req_ch.sample_2  <= '0;
      req_ch.sample_3  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= acmm_pkg::CSR_COEF_ROW_0;
      csr_write_data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: identity matrix, two channels in and out.
      send_frame(make_frame(smax, smin, 5, 7));
      send_frame(make_frame(-1, 1, 100, -100));
      send_frame(make_frame(0, 0, 0, 0));

      // Largest positive coefficient everywhere: clips both ways.
      settle();
      program_mixer(flat_config(16'h7FFF, 4, 4, 1'b0));
      send_frame(make_frame(smax, smax, smax, smax));
      send_frame(make_frame(smin, smin, smin, smin));
      send_frame(make_frame(1, 1, 1, 1));

      // Most negative coefficient everywhere.
      settle();
      program_mixer(flat_config(16'h8000, 4, 4, 1'b0));
      send_frame(make_frame(smin, smin, smin, smin));
      send_frame(make_frame(smax, smax, smax, smax));
      send_frame(make_frame(-1, 0, 0, 0));

      // Half a step past full scale still clips; fractions truncate toward zero.
      settle();
      cfg = flat_config(16'h1000, 2, 3, 1'b0);
      cfg.row[1] = {acmm_pkg::LANES{16'h0800}};
      program_mixer(cfg);
      send_frame(make_frame(smax, 1, 0, 0));
      send_frame(make_frame(smin, -1, 0, 0));
      send_frame(make_frame(smax - 1, 1, 0, 0));
      send_frame(make_frame(0, -3, 0, 0));
      send_frame(make_frame(0, 3, 0, 0));

      // No active inputs, then no active outputs.
      settle();
      program_mixer(random_config(0, 4, 1'b0));
      send_frame(make_frame(smax, smin, smax, smin));
      send_frame(make_frame(123456, -654321, 7, -7));
      settle();
      program_mixer(random_config(3, 0, 1'b0));
      send_frame(make_frame(smax, smax, smax, smax));
      send_frame(make_frame(smin, smin, smin, smin));

      // Counts beyond four, with every input on row zero.
      settle();
      program_mixer(random_config(7, 5, 1'b1));
      send_frame(make_frame(smax, smax, smax, smax));
      send_frame(make_frame(smin, smax, smin, smax));
      send_frame(make_frame(-1, -2, -3, -4));

      settle();
      program_mixer(random_config(4, 4, 1'b0));
      send_frame(make_frame(smax, smin, -1, 1));
      send_frame(make_frame(1, -1, smin, smax));

      // Random phases: each with its own settings; the idling pattern changes every three phases.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         if (p < 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 77;
         end else if (p < 6) begin
            send_idle_pct = 77;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_mixer(random_config(in_pick[p], out_pick[p], 1'(p % 2)));
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            if (n == PHASE_FRAMES / 2) settle();
            send_frame(make_frame(random_sample(), random_sample(),
                                  random_sample(), random_sample()));
         end
      end

      settle();
      repeat (4 * PIPE_LATENCY) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
